// ===== sv/box_blur_3x3_rgb_assert.svh =====
// Assertion macros shared by the blur RTL.
// Needs a clock named clk and an active-high reset named rst in scope.
`ifndef BOX_BLUR_3X3_RGB_ASSERT_SVH
`define BOX_BLUR_3X3_RGB_ASSERT_SVH

// Checked only outside reset.
`define BB3_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define BB3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/bb3_pkg.sv =====
// Package for the 3x3 RGB box blur: defaults, register map, fixed widths.
// No dependencies.
package bb3_pkg;

  localparam int MAX_WIDTH_DEF    = 1024;
  localparam int CHANNEL_BITS_DEF = 8;

  localparam int ROW_BITS        = 12;
  localparam int WIDTH_REG_BITS  = 11;
  localparam int HEIGHT_REG_BITS = 13;
  localparam int CFG_DATA_BITS   = 13;
  localparam int CFG_INDEX_BITS  = 2;

  localparam int MIN_DIM    = 3;
  localparam int MAX_HEIGHT = 4096;

  localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = WIDTH_REG_BITS'(512);
  localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = HEIGHT_REG_BITS'(512);

  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = CFG_INDEX_BITS'(1);

endpackage

// ===== sv/bb3_line_store.sv =====
// Line store for the box blur: one entry per column holding the two
// previous lines of that column. Simple dual-port RAM with registered read.
module bb3_line_store #(
  parameter int DEPTH     = 1024,
  parameter int DATA_BITS = 48
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [$clog2(DEPTH)-1:0]     rd_addr,
  output logic [DATA_BITS-1:0]         rd_data,
  input  logic                         wr_en,
  input  logic [$clog2(DEPTH)-1:0]     wr_addr,
  input  logic [DATA_BITS-1:0]         wr_data
);

  logic [DATA_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds while no new read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/box_blur_3x3_rgb.sv =====
// 3x3 box blur on an RGB raster stream, one pixel per clock unless m_tready stalls.
// A taken pixel and its line store read are registered in stage 1, the window sum
// in stage 2, and the multiply by the reciprocal of nine in the m_tvalid register.
// Border pixels give no result; the last interior result of a frame has m_tlast.
// Reset (rst, synchronous) clears counters, window and pipeline valids and sets
// both size registers to 512; the line store is not cleared and needs no pass.
`include "box_blur_3x3_rgb_assert.svh"

module box_blur_3x3_rgb #(
  parameter int MAX_WIDTH    = bb3_pkg::MAX_WIDTH_DEF,
  parameter int CHANNEL_BITS = bb3_pkg::CHANNEL_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  // s_tdata fields from bit 0: red_in, green_in, blue_in, zero fill
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  input  logic [((3*CHANNEL_BITS+7)/8)*8-1:0]     s_tdata,
  // m_tdata fields from bit 0: red_out, green_out, blue_out, center_col,
  // center_row, zero fill; m_tlast carries frame_last
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  output logic [((3*CHANNEL_BITS+$clog2(MAX_WIDTH)+bb3_pkg::ROW_BITS+7)/8)*8-1:0]
                                                  m_tdata,
  output logic                                    m_tlast,
  input  logic                                    cfg_we,
  input  logic [bb3_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
  input  logic [bb3_pkg::CFG_DATA_BITS-1:0]       cfg_data
);

  localparam int COL_BITS  = $clog2(MAX_WIDTH);
  localparam int ROW_BITS  = bb3_pkg::ROW_BITS;
  localparam int HB        = bb3_pkg::HEIGHT_REG_BITS;
  localparam int PIX_BITS  = 3 * CHANNEL_BITS;
  localparam int SUM_BITS  = CHANNEL_BITS + 4;
  localparam int PROD_BITS = 2 * SUM_BITS + 1;
  localparam int OUT_BITS  = PIX_BITS + COL_BITS + ROW_BITS;
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;
  localparam int WCMP      = (COL_BITS + 1 > bb3_pkg::WIDTH_REG_BITS) ?
                             COL_BITS + 1 : bb3_pkg::WIDTH_REG_BITS;
  // floor(x / 9) = (x * DIV_MULT) >> DIV_SHIFT for every x below 2**SUM_BITS.
  localparam int DIV_SHIFT = SUM_BITS + 4;
  localparam logic [SUM_BITS:0] DIV_MULT =
    (SUM_BITS + 1)'(((64'd1 << DIV_SHIFT) + 64'd8) / 64'd9);

  // Configuration and frame position.
  logic [bb3_pkg::WIDTH_REG_BITS-1:0] image_width;
  logic [HB-1:0]                      image_height;
  logic [COL_BITS-1:0]                col_count;
  logic [ROW_BITS-1:0]                row_count;

  logic [COL_BITS:0]   eff_w;
  logic [HB-1:0]       eff_h;
  logic [WCMP-1:0]     w_wide;
  logic [COL_BITS-1:0] col_cur;
  logic [ROW_BITS-1:0] row_cur;
  logic [COL_BITS:0]   col_ext;
  logic [HB-1:0]       row_ext;
  logic                col_wrap;
  logic                row_wrap;
  logic                cur_res;
  logic                cur_last;
  logic                accept;

  // Pipeline registers.
  logic                s1_valid;
  logic [PIX_BITS-1:0] s1_pix;
  logic [COL_BITS-1:0] s1_col;
  logic [ROW_BITS-1:0] s1_row;
  logic                s1_res;
  logic                s1_last;
  logic                s1_adv;

  logic [PIX_BITS-1:0] win [6];
  logic [2*PIX_BITS-1:0] lb_rd_data;
  logic [PIX_BITS-1:0] rd_top;
  logic [PIX_BITS-1:0] rd_mid;
  logic [SUM_BITS-1:0] sum_next [3];

  logic                s2_valid;
  logic [SUM_BITS-1:0] s2_sum [3];
  logic [COL_BITS-1:0] s2_col;
  logic [ROW_BITS-1:0] s2_row;
  logic                s2_last;
  logic                s2_adv;
  logic                s2_free;
  logic                out_ready;

  logic [PROD_BITS-1:0]     prod [3];
  logic [CHANNEL_BITS-1:0]  res_ch [3];
  logic [COL_BITS-1:0]      res_col;
  logic [ROW_BITS-1:0]      res_row;
  logic                     last_pos_ok;

  always_comb begin
    w_wide = WCMP'(image_width);
    if (w_wide < WCMP'(bb3_pkg::MIN_DIM)) begin
      eff_w = (COL_BITS + 1)'(bb3_pkg::MIN_DIM);
    end else if (w_wide > WCMP'(MAX_WIDTH)) begin
      eff_w = (COL_BITS + 1)'(MAX_WIDTH);
    end else begin
      eff_w = (COL_BITS + 1)'(w_wide);
    end
    if (image_height < HB'(bb3_pkg::MIN_DIM)) begin
      eff_h = HB'(bb3_pkg::MIN_DIM);
    end else if (image_height > HB'(bb3_pkg::MAX_HEIGHT)) begin
      eff_h = HB'(bb3_pkg::MAX_HEIGHT);
    end else begin
      eff_h = image_height;
    end
  end

  assign col_cur  = ((COL_BITS + 1)'(col_count) >= eff_w) ? '0 : col_count;
  assign row_cur  = (HB'(row_count) >= eff_h) ? '0 : row_count;
  assign col_ext  = (COL_BITS + 1)'(col_cur);
  assign row_ext  = HB'(row_cur);
  assign col_wrap = (col_ext + 1'b1) >= eff_w;
  assign row_wrap = (row_ext + 1'b1) >= eff_h;
  assign cur_res  = (row_cur >= ROW_BITS'(2)) && (col_cur >= COL_BITS'(2));
  assign cur_last = (row_ext == eff_h - 1'b1) && (col_ext == eff_w - 1'b1);

  // Ready flows back through the stages; a pixel with no result needs no slot.
  assign out_ready = !m_tvalid || m_tready;
  assign s2_free   = !s2_valid || out_ready;
  assign s2_adv    = s2_valid && out_ready;
  assign s1_adv    = s1_valid && (s2_free || !s1_res);
  assign s_tready  = !s1_valid || s1_adv;
  assign accept    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= bb3_pkg::WIDTH_RESET;
      image_height <= bb3_pkg::HEIGHT_RESET;
      col_count    <= '0;
      row_count    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bb3_pkg::REG_IMAGE_WIDTH: begin
          image_width <= cfg_data[bb3_pkg::WIDTH_REG_BITS-1:0];
          col_count   <= '0;
          row_count   <= '0;
        end
        bb3_pkg::REG_IMAGE_HEIGHT: begin
          image_height <= cfg_data[HB-1:0];
          col_count    <= '0;
          row_count    <= '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      if (col_wrap) begin
        col_count <= '0;
        row_count <= row_wrap ? '0 : row_cur + 1'b1;
      end else begin
        col_count <= col_cur + 1'b1;
        row_count <= row_cur;
      end
    end
  end

  // Each entry holds {line two above, line above} for one column. A pixel
  // reads its column when taken and writes it back one stage later; the next
  // pixel is in another column (barring a size write), so the two do not collide.
  bb3_line_store #(
    .DEPTH     (MAX_WIDTH),
    .DATA_BITS (2 * PIX_BITS)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_cur),
    .rd_data (lb_rd_data),
    .wr_en   (s1_adv),
    .wr_addr (s1_col),
    .wr_data ({rd_mid, s1_pix})
  );

  assign rd_top = lb_rd_data[2*PIX_BITS-1:PIX_BITS];
  assign rd_mid = lb_rd_data[PIX_BITS-1:0];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum_next[k] = SUM_BITS'(rd_top[k*CHANNEL_BITS +: CHANNEL_BITS])
                  + SUM_BITS'(rd_mid[k*CHANNEL_BITS +: CHANNEL_BITS])
                  + SUM_BITS'(s1_pix[k*CHANNEL_BITS +: CHANNEL_BITS])
                  + SUM_BITS'(win[0][k*CHANNEL_BITS +: CHANNEL_BITS])
                  + SUM_BITS'(win[1][k*CHANNEL_BITS +: CHANNEL_BITS])
                  + SUM_BITS'(win[2][k*CHANNEL_BITS +: CHANNEL_BITS])
                  + SUM_BITS'(win[3][k*CHANNEL_BITS +: CHANNEL_BITS])
                  + SUM_BITS'(win[4][k*CHANNEL_BITS +: CHANNEL_BITS])
                  + SUM_BITS'(win[5][k*CHANNEL_BITS +: CHANNEL_BITS]);
      prod[k] = PROD_BITS'(s2_sum[k]) * PROD_BITS'(DIV_MULT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end

      if (s1_adv) begin
        win[0] <= win[3];
        win[1] <= win[4];
        win[2] <= win[5];
        win[3] <= rd_top;
        win[4] <= rd_mid;
        win[5] <= s1_pix;
      end

      if (s1_adv && s1_res) begin
        s2_valid <= 1'b1;
      end else if (s2_adv) begin
        s2_valid <= 1'b0;
      end

      if (s2_adv) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix  <= s_tdata[PIX_BITS-1:0];
      s1_col  <= col_cur;
      s1_row  <= row_cur;
      s1_res  <= cur_res;
      s1_last <= cur_last;
    end
    if (s1_adv && s1_res) begin
      for (int k = 0; k < 3; k++) begin
        s2_sum[k] <= sum_next[k];
      end
      s2_col  <= s1_col - 1'b1;
      s2_row  <= s1_row - 1'b1;
      s2_last <= s1_last;
    end
    if (s2_adv) begin
      for (int k = 0; k < 3; k++) begin
        res_ch[k] <= prod[k][DIV_SHIFT +: CHANNEL_BITS];
      end
      res_col <= s2_col;
      res_row <= s2_row;
      m_tlast <= s2_last;
    end
  end

  assign m_tdata = OUT_W'({res_row, res_col, res_ch[2], res_ch[1], res_ch[0]});

  assign last_pos_ok = ((COL_BITS + 1)'(res_col) == eff_w - 2'd2)
                    && (HB'(res_row) == eff_h - 2'd2);

  `BB3_ASSERT(a_reset_drains_output, rst |=> !m_tvalid && !s1_valid && !s2_valid, "pipeline valid after reset")
  `BB3_ASSERT_RST(a_no_ram_collision, (accept && s1_adv) |-> (s1_col != col_cur), "line store read and write hit one column")
  `BB3_ASSERT_RST(a_col_in_range, col_ext < eff_w, "column counter outside the line")
  `BB3_ASSERT_RST(a_last_at_corner, (m_tvalid && m_tlast) |-> last_pos_ok, "frame end flagged away from the last interior pixel")
  `BB3_ASSERT_RST(a_center_interior, m_tvalid |-> (res_col != '0) && (res_row != '0), "result centered on a border pixel")

endmodule
